[sv/b2bcd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Binary to BCD converter package
// Shared sizes, controller states and the command and status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package b2bcd_pkg;

  localparam int MAX_INPUT_BYTES = 8;
  localparam int BCD_DIGITS      = 20;
  localparam int BITS_PER_BYTE   = 8;

  localparam int PAIR_COUNT = (BCD_DIGITS + 1) / 2;
  localparam int BCD_W      = BCD_DIGITS * 4;
  localparam int PAIR_REG_W = PAIR_COUNT * 8;
  localparam int CNT_W      = $clog2(MAX_INPUT_BYTES + 1);
  localparam int BIT_W      = $clog2(BITS_PER_BYTE);

  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_INPUT_BYTES);
  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(BITS_PER_BYTE - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic set_ovf;
    logic step;
    logic shift_out;
  } cmd_t;

  typedef struct packed {
    logic top_pair;
  } sts_t;

endpackage : b2bcd_pkg
`default_nettype wire

[sv/binary_to_bcd_double_dabble_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Binary to BCD converter, double dabble
// Takes an unsigned magnitude one byte word at a time, most significant byte
// first, and returns packed BCD digit pairs after the last byte.
// ----------------------------------------------------------------------------
// The block handles one word at a time. An accepted byte is captured into the
// data register and then shifted into the full digit register with one
// add-3-and-shift step per input bit, one bit per cycle. A byte beyond the
// capacity is dropped in its accept cycle and raises overflow. After the last
// byte the digit pairs leave one per cycle, least significant first, up to
// the highest nonzero pair, while out_ready is high; no new byte is taken
// until the top pair has been delivered.
module binary_to_bcd_double_dabble_top import b2bcd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_sign_in,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [7:0] out_digit_pair,
  output logic            out_sign_out,
  output logic            out_last_pair,
  output logic            out_overflow
);

  cmd_t cmd;
  sts_t sts;

  b2bcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_last   (in_last_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  b2bcd_dp u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .sts     (sts),
    .in_byte (in_data_byte),
    .in_sign (in_sign_in),
    .pair    (out_digit_pair),
    .sign    (out_sign_out),
    .ovf     (out_overflow)
  );

  assign out_last_pair = sts.top_pair;

  a_no_overlap : assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output sides active together");

  a_more_pairs : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_pair |=> out_valid)
    else $error("pair sequence ended before the top pair");

  a_back_to_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_pair |=> in_ready && !out_valid)
    else $error("block did not return to idle after the top pair");

  a_flags_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_pair |=>
      $stable(out_overflow) && $stable(out_sign_out))
    else $error("sign or overflow changed within one number");

endmodule : binary_to_bcd_double_dabble_top
`default_nettype wire

[sv/b2bcd_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Binary to BCD datapath
// Holds the byte being shifted in, the packed BCD digit register, the sign
// and the overflow flag, and performs one add-3-and-shift step per command.
// ----------------------------------------------------------------------------
module b2bcd_dp import b2bcd_pkg::*; (
  input  wire logic                     clk,
  input  wire cmd_t                     cmd,
  output sts_t                          sts,
  input  wire logic [BITS_PER_BYTE-1:0] in_byte,
  input  wire logic                     in_sign,
  output logic      [7:0]               pair,
  output logic                          sign,
  output logic                          ovf
);

  logic [BITS_PER_BYTE-1:0] data_r, data_nxt;
  logic [PAIR_REG_W-1:0]    digits_r, digits_nxt;
  logic                     sign_r, sign_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [BCD_W-1:0]         adj;

  always_comb begin
    logic [3:0] d;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      d = digits_r[i*4 +: 4];
      adj[i*4 +: 4] = (d > 4'd4) ? 4'(d + 4'd3) : d;
    end
  end

  always_comb begin
    data_nxt   = data_r;
    digits_nxt = digits_r;
    sign_nxt   = sign_r;
    ovf_nxt    = ovf_r;
    if (cmd.load) begin
      data_nxt = in_byte;
    end
    if (cmd.clear) begin
      digits_nxt = '0;
      sign_nxt   = in_sign;
      ovf_nxt    = 1'b0;
    end
    if (cmd.set_ovf) begin
      ovf_nxt = 1'b1;
    end
    if (cmd.step) begin
      digits_nxt = '0;
      digits_nxt[BCD_W-1:0] = {adj[BCD_W-2:0], data_r[BITS_PER_BYTE-1]};
      data_nxt = {data_r[BITS_PER_BYTE-2:0], 1'b0};
    end
    if (cmd.shift_out) begin
      digits_nxt = digits_r >> 8;
    end
  end

  always_ff @(posedge clk) begin
    data_r   <= data_nxt;
    digits_r <= digits_nxt;
    sign_r   <= sign_nxt;
    ovf_r    <= ovf_nxt;
  end

  assign sts.top_pair = (digits_r[PAIR_REG_W-1:8] == '0);
  assign pair = digits_r[7:0];
  assign sign = sign_r;
  assign ovf  = ovf_r;

endmodule : b2bcd_dp
`default_nettype wire

[sv/b2bcd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Binary to BCD controller
// Sequences byte acceptance, the eight shift steps per byte and the output
// of digit pairs, and keeps the byte count of the current number.
// ----------------------------------------------------------------------------
module b2bcd_ctrl import b2bcd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic in_last,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;
  logic             last_r, last_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    bit_nxt   = bit_r;
    last_nxt  = last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          last_nxt = in_last;
          bit_nxt  = '0;
          if (cnt_r < MAX_CNT) begin
            cnt_nxt   = CNT_W'(cnt_r + 1'b1);
            state_nxt = ST_SHIFT;
          end else if (in_last) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_SHIFT: begin
        bit_nxt = BIT_W'(bit_r + 1'b1);
        if (bit_r == LAST_BIT) begin
          state_nxt = last_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_ready && sts.top_pair) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load    = in_valid;
        cmd.clear   = in_valid && (cnt_r == '0);
        cmd.set_ovf = in_valid && (cnt_r >= MAX_CNT);
      end
      ST_SHIFT: begin
        cmd.step = 1'b1;
      end
      ST_EMIT: begin
        out_valid     = 1'b1;
        cmd.shift_out = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      bit_r   <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      bit_r   <= bit_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule : b2bcd_ctrl
`default_nettype wire
